[src/shabs_pkg.sv]
// shared types, constants and round functions of the sha-256 byte stream hasher
package shabs_pkg;

    localparam int unsigned WordW       = 32;
    localparam int unsigned ByteW       = 8;
    localparam int unsigned BlockWords  = 16;
    localparam int unsigned ChainWords  = 8;
    localparam int unsigned FillW       = 6;
    localparam int unsigned RoundW      = 6;
    localparam int unsigned IdxW        = 3;
    localparam int unsigned CountW      = 64;
    localparam logic [FillW-1:0]  LenStart   = FillW'(56);
    localparam logic [FillW-1:0]  FillLast   = FillW'(63);
    localparam logic [RoundW-1:0] RoundLast  = RoundW'(63);
    localparam logic [IdxW-1:0]   IdxLast    = IdxW'(7);
    localparam logic [ByteW-1:0]  PadMark    = 8'h80;
    localparam logic [CountW-1:0] BlockBits  = CountW'(512);

    localparam logic [WordW-1:0] Iv [ChainWords] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_sel_t;

    typedef struct packed {
        logic              load_byte;
        logic              pad_shift;
        pad_sel_t          pad_sel;
        logic              init_work;
        logic              round;
        logic [RoundW-1:0] round_idx;
        logic              add_chain;
        logic              count_block;
        logic              reinit;
        logic [IdxW-1:0]   word_idx;
    } cmd_t;

    typedef struct packed {
        logic [FillW-1:0] fill;
    } status_t;

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (WordW - n));
    endfunction

    function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
        logic [WordW-1:0] k;
        unique case (t)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
            default: k = '0;
        endcase
        round_k = k;
    endfunction

endpackage

[src/shabs_datapath.sv]
// datapath: block window, message schedule, round logic, chaining words and length
module shabs_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  shabs_pkg::cmd_t                       cmd,
    input  logic [shabs_pkg::ByteW-1:0]           data_byte,
    output shabs_pkg::status_t                    status,
    output logic [shabs_pkg::WordW-1:0]           digest_word
);

    logic [shabs_pkg::WordW-1:0]  window_reg [shabs_pkg::BlockWords];
    logic [shabs_pkg::WordW-1:0]  work_reg   [shabs_pkg::ChainWords];
    logic [shabs_pkg::WordW-1:0]  chain_reg  [shabs_pkg::ChainWords];
    logic [shabs_pkg::FillW-1:0]  fill_reg;
    logic [shabs_pkg::CountW-1:0] bit_count_reg;
    logic [shabs_pkg::CountW-1:0] total_reg;

    logic [shabs_pkg::ByteW-1:0]  byte_in;
    logic [shabs_pkg::WordW-1:0]  sched_next;
    logic [shabs_pkg::WordW-1:0]  t1;
    logic [shabs_pkg::WordW-1:0]  t2;
    logic [shabs_pkg::WordW-1:0]  ch;
    logic [shabs_pkg::WordW-1:0]  maj;
    logic [shabs_pkg::CountW-1:0] total_next;

    always_comb
    begin
        unique case ({cmd.pad_shift, cmd.pad_sel})
            {1'b1, shabs_pkg::PAD_MARK}: byte_in = shabs_pkg::PadMark;
            {1'b1, shabs_pkg::PAD_LEN}:  byte_in = total_reg[shabs_pkg::CountW-1 -: shabs_pkg::ByteW];
            {1'b1, shabs_pkg::PAD_ZERO}: byte_in = '0;
            default:                     byte_in = data_byte;
        endcase
    end

    assign total_next = bit_count_reg + {{(shabs_pkg::CountW-shabs_pkg::FillW-3){1'b0}}, fill_reg, 3'b000};

    assign sched_next = shabs_pkg::small_sigma1(window_reg[14]) + window_reg[9]
                      + shabs_pkg::small_sigma0(window_reg[1]) + window_reg[0];

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + shabs_pkg::big_sigma1(work_reg[4]) + ch
               + shabs_pkg::round_k(cmd.round_idx) + window_reg[0];
    assign t2  = shabs_pkg::big_sigma0(work_reg[0]) + maj;

    // window and working words carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte || cmd.pad_shift)
        begin
            for (int i = 0; i < shabs_pkg::BlockWords - 1; i++)
            begin
                window_reg[i] <= {window_reg[i][shabs_pkg::WordW-shabs_pkg::ByteW-1:0],
                                  window_reg[i+1][shabs_pkg::WordW-1 -: shabs_pkg::ByteW]};
            end
            window_reg[shabs_pkg::BlockWords-1] <=
                {window_reg[shabs_pkg::BlockWords-1][shabs_pkg::WordW-shabs_pkg::ByteW-1:0], byte_in};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < shabs_pkg::BlockWords - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[shabs_pkg::BlockWords-1] <= sched_next;
        end

        if (cmd.init_work)
        begin
            for (int i = 0; i < shabs_pkg::ChainWords; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end

        if (cmd.pad_shift && cmd.pad_sel == shabs_pkg::PAD_MARK)
        begin
            total_reg <= total_next;
        end
        else if (cmd.pad_shift && cmd.pad_sel == shabs_pkg::PAD_LEN)
        begin
            total_reg <= {total_reg[shabs_pkg::CountW-shabs_pkg::ByteW-1:0], {shabs_pkg::ByteW{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < shabs_pkg::ChainWords; i++)
            begin
                chain_reg[i] <= shabs_pkg::Iv[i];
            end
            fill_reg      <= '0;
            bit_count_reg <= '0;
        end
        else
        begin
            if (cmd.load_byte || cmd.pad_shift)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.reinit)
            begin
                for (int i = 0; i < shabs_pkg::ChainWords; i++)
                begin
                    chain_reg[i] <= shabs_pkg::Iv[i];
                end
                bit_count_reg <= '0;
            end
            else
            begin
                if (cmd.add_chain)
                begin
                    for (int i = 0; i < shabs_pkg::ChainWords; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.count_block)
                begin
                    bit_count_reg <= bit_count_reg + shabs_pkg::BlockBits;
                end
            end
        end
    end

    assign status.fill = fill_reg;
    assign digest_word = chain_reg[cmd.word_idx];

endmodule

[src/shabs_ctrl.sv]
// controller: byte intake, compression rounds, padding and digest output sequencing
module shabs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          end_of_message,
    input  logic                          no_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [shabs_pkg::IdxW-1:0]    word_index,
    output logic                          last_word,
    input  shabs_pkg::status_t            status,
    output shabs_pkg::cmd_t               cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [shabs_pkg::RoundW-1:0]  round_reg;
    logic [shabs_pkg::IdxW-1:0]    idx_reg;
    logic                          end_pending_reg;
    logic                          data_block_reg;
    logic                          mark_done_reg;
    logic                          extra_reg;

    logic in_xfer;
    logic out_xfer;
    logic fill_full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign fill_full = (status.fill == shabs_pkg::FillLast);

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == shabs_pkg::IdxLast);

    always_comb
    begin
        cmd             = '0;
        cmd.pad_sel     = shabs_pkg::PAD_ZERO;
        cmd.round_idx   = round_reg;
        cmd.word_idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_byte = in_xfer && !no_byte;
                cmd.init_work = in_xfer && !no_byte && fill_full;
            end
            ST_COMPRESS:
            begin
                cmd.round = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add_chain   = 1'b1;
                cmd.count_block = data_block_reg;
            end
            ST_PAD:
            begin
                cmd.pad_shift = 1'b1;
                cmd.init_work = fill_full;
                priority if (!mark_done_reg)
                    cmd.pad_sel = shabs_pkg::PAD_MARK;
                else if (status.fill >= shabs_pkg::LenStart && !extra_reg)
                    cmd.pad_sel = shabs_pkg::PAD_LEN;
                else
                    cmd.pad_sel = shabs_pkg::PAD_ZERO;
            end
            ST_EMIT:
            begin
                cmd.reinit = out_xfer && last_word;
            end
            default:
            begin
                cmd.round = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            round_reg       <= '0;
            idx_reg         <= '0;
            end_pending_reg <= 1'b0;
            data_block_reg  <= 1'b0;
            mark_done_reg   <= 1'b0;
            extra_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        end_pending_reg <= end_of_message;
                        mark_done_reg   <= 1'b0;
                        if (!no_byte && fill_full)
                        begin
                            data_block_reg <= 1'b1;
                            round_reg      <= '0;
                            state_reg      <= ST_COMPRESS;
                        end
                        else if (end_of_message)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_COMPRESS:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == shabs_pkg::RoundLast)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    priority if (data_block_reg)
                    begin
                        state_reg <= end_pending_reg ? ST_PAD : ST_IDLE;
                    end
                    else if (extra_reg)
                    begin
                        extra_reg <= 1'b0;
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_PAD:
                begin
                    if (!mark_done_reg)
                    begin
                        mark_done_reg <= 1'b1;
                        extra_reg     <= (status.fill >= shabs_pkg::LenStart);
                    end
                    if (fill_full)
                    begin
                        data_block_reg <= 1'b0;
                        round_reg      <= '0;
                        state_reg      <= ST_COMPRESS;
                    end
                end
                ST_EMIT:
                begin
                    if (out_xfer)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (last_word)
                        begin
                            end_pending_reg <= 1'b0;
                            state_reg       <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/sha256_byte_stream_hasher.sv]
// top level of the sha-256 byte stream hasher: controller plus datapath
// a byte that does not complete a block is taken directly; the 64th byte of a block starts
// the compression (64 rounds on one shared round unit, then the chaining add) before the next byte is taken
// an end transfer adds one padding byte per cycle outside compression (up to 64 per block, 72 over two blocks),
// and compresses each padding block (one or two), then makes 8 output transfers; one message at a time
// asynchronous active-low reset loads the initial hash values and clears fill and bit count
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    input  logic        no_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    shabs_pkg::cmd_t    cmd;
    shabs_pkg::status_t status;

    shabs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .end_of_message (end_of_message),
        .no_byte        (no_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .status         (status),
        .cmd            (cmd)
    );

    shabs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

[dv/sha256_byte_stream_hasher_test.sv]
// self-checking testbench of the sha-256 byte stream hasher with its own digest predictor
module sha256_byte_stream_hasher_test;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned ItemTarget = 330;
    localparam int unsigned TailItems  = 40;
    localparam int unsigned SettleCycles = 300;

    localparam logic [31:0] HashInit [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       nb;
        logic       drain_first;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_message = 1'b0;
    logic        no_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    byte_item_t   byte_items [$];
    digest_word_t digest_words_due [$];

    logic [31:0] hash_chain [8];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [63:0] bits_hashed;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    logic        send_calm = 1'b0;
    logic        recv_calm = 1'b0;

    sha256_byte_stream_hasher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .no_byte        (no_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] rot_right(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic restart_message();
        hash_chain = HashInit;
        block_fill = 0;
        bits_hashed = '0;
    endtask

    task automatic compress_block_bytes();
        logic [31:0] sched [64];
        logic [31:0] wv [8];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        int t;
        for (t = 0; t < 16; t++)
        begin
            sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                        block_bytes[4*t+3]};
        end
        for (t = 16; t < 64; t++)
        begin
            s0 = rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
        end
        wv = hash_chain;
        for (t = 0; t < 64; t++)
        begin
            t1 = wv[7] + (rot_right(wv[4], 6) ^ rot_right(wv[4], 11) ^ rot_right(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RoundConst[t] + sched[t];
            t2 = (rot_right(wv[0], 2) ^ rot_right(wv[0], 13) ^ rot_right(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++)
        begin
            hash_chain[t] = hash_chain[t] + wv[t];
        end
    endtask

    task automatic hash_absorb_item(input byte_item_t it);
        logic [63:0]  total;
        digest_word_t dw;
        int k;
        if (!it.nb)
        begin
            block_bytes[block_fill] = it.data;
            block_fill = block_fill + 1;
            if (block_fill == 64)
            begin
                compress_block_bytes();
                bits_hashed = bits_hashed + 64'd512;
                block_fill = 0;
            end
        end
        if (it.eom)
        begin
            total = bits_hashed + 64'(block_fill) * 64'd8;
            block_bytes[block_fill] = 8'h80;
            block_fill = block_fill + 1;
            if (block_fill > 56)
            begin
                while (block_fill < 64)
                begin
                    block_bytes[block_fill] = 8'h00;
                    block_fill = block_fill + 1;
                end
                compress_block_bytes();
                block_fill = 0;
            end
            while (block_fill < 56)
            begin
                block_bytes[block_fill] = 8'h00;
                block_fill = block_fill + 1;
            end
            for (k = 0; k < 8; k++)
            begin
                block_bytes[56+k] = total[63-8*k -: 8];
            end
            compress_block_bytes();
            for (k = 0; k < 8; k++)
            begin
                dw.word = hash_chain[k];
                dw.idx = 3'(k);
                dw.last = (k == 7);
                digest_words_due.push_back(dw);
            end
            restart_message();
        end
    endtask

    // driver: one item in flight, idle bursts between transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            end_of_message <= 1'b0;
            no_byte <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hash_absorb_item(byte_items[0]);
                void'(byte_items.pop_front());
            end
            if ($urandom_range(0, 63) == 0)
                send_calm = ~send_calm;
            if (in_valid && !in_ready)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (byte_items.size() == 0 ||
                     (byte_items[0].drain_first && digest_words_due.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else if (!send_calm && byte_items.size() > TailItems && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 9);
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                data_byte <= byte_items[0].data;
                end_of_message <= byte_items[0].eom;
                no_byte <= byte_items[0].nb;
            end
        end
    end

    // monitor: checks each digest word transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t dw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_words_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual word %h index %0d last %0d",
                             $time, digest_word, word_index, last_word);
                    error_count++;
                end
                else
                begin
                    dw = digest_words_due.pop_front();
                    if (digest_word !== dw.word)
                    begin
                        $display("%0t: digest_word expected %h actual %h", $time, dw.word,
                                 digest_word);
                        error_count++;
                    end
                    if (word_index !== dw.idx)
                    begin
                        $display("%0t: word_index expected %0d actual %0d", $time, dw.idx,
                                 word_index);
                        error_count++;
                    end
                    if (last_word !== dw.last)
                    begin
                        $display("%0t: last_word expected %0d actual %0d", $time, dw.last,
                                 last_word);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0)
                recv_calm = ~recv_calm;
            if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!recv_calm && byte_items.size() > TailItems && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("sha256_byte_stream_hasher_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned counted;
        int unsigned len;
        int unsigned pick;
        int unsigned i;
        int unsigned edge_lens [11];
        logic        byte_end;
        logic        hold;
        byte_item_t  it;

        edge_lens = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};
        counted = 0;
        restart_message();

        // directed: ignored item, empty messages, "abc", single-byte extremes, a two-byte message
        it = '{data: 8'hA5, eom: 1'b0, nb: 1'b1, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'h00, eom: 1'b1, nb: 1'b1, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'h61, eom: 1'b0, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'h62, eom: 1'b0, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'h63, eom: 1'b1, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'h00, eom: 1'b1, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'hFF, eom: 1'b0, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'h5A, eom: 1'b1, nb: 1'b1, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'hFF, eom: 1'b0, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'hFF, eom: 1'b1, nb: 1'b0, drain_first: 1'b0};
        byte_items.push_back(it);
        it = '{data: 8'hFF, eom: 1'b1, nb: 1'b1, drain_first: 1'b0};
        byte_items.push_back(it);
        counted = 10;

        // random messages, first a sweep over the padding boundaries
        pick = 0;
        while (counted < ItemTarget)
        begin
            if (pick < 5)
            begin
                len = (pick < 4) ? edge_lens[pick + 1] : 64;
                byte_end = (pick != 4);
                hold = (pick == 0);
            end
            else
            begin
                i = $urandom_range(0, 9);
                if (i < 5)
                    len = $urandom_range(0, 20);
                else if (i < 8)
                    len = edge_lens[$urandom_range(0, 10)];
                else if (i == 8)
                    len = 0;
                else
                    len = $urandom_range(1, 140);
                byte_end = $urandom_range(0, 1);
                hold = ($urandom_range(0, 9) == 0);
            end
            pick++;
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    it = '{data: 8'($urandom), eom: 1'b0, nb: 1'b1, drain_first: hold};
                    byte_items.push_back(it);
                    hold = 1'b0;
                end
                it.data = 8'($urandom);
                it.eom = byte_end && (i == len - 1);
                it.nb = 1'b0;
                it.drain_first = hold;
                byte_items.push_back(it);
                hold = 1'b0;
                counted++;
            end
            if (!byte_end || len == 0)
            begin
                it = '{data: 8'($urandom), eom: 1'b1, nb: 1'b1, drain_first: hold};
                byte_items.push_back(it);
                counted++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (byte_items.size() != 0 || in_valid)
            @(posedge clk);
        while (digest_words_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (error_count == 0 && digest_words_due.size() == 0)
            $display("sha256_byte_stream_hasher_test OK");
        else
            $display("sha256_byte_stream_hasher_test NOT OK");
        $finish;
    end

endmodule
